>>> rtl/bcn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcn_pkg
// Shared types and codes of the BCn texture block decoder: channel payloads,
// format mode codes and the decoded block command passed from front to back.
// ----------------------------------------------------------------------------
package bcn_pkg;

   localparam logic [2:0] MODE_DXT1_OPAQUE = 3'd0;
   localparam logic [2:0] MODE_DXT1_ALPHA  = 3'd1;
   localparam logic [2:0] MODE_DXT1_BE     = 3'd2;
   localparam logic [2:0] MODE_DXT3        = 3'd3;
   localparam logic [2:0] MODE_DXT5        = 3'd4;
   localparam logic [2:0] MODE_BC4         = 3'd5;
   localparam logic [2:0] MODE_BC5         = 3'd6;

   localparam logic [3:0] LAST_PIXEL_POS = 4'hF;

   typedef struct packed {
      logic [63:0] block_word0;
      logic [63:0] block_word1;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_argb;
      logic [3:0]  pixel_position;
      logic        last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [3:0][31:0] pal;
      logic [31:0]      idx;
      logic [63:0]      w0;
      logic [63:0]      w1;
   } cmd_type;

endpackage

>>> rtl/bcn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcn_front
// Accepts one block, classifies it by format mode, builds the colour palette
// and normalizes the index word, then hands the command to the queue.
// ----------------------------------------------------------------------------
module bcn_front import bcn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [2:0]    format_mode,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          cmd_valid,
   input  logic          cmd_ready,
   output cmd_type       cmd_data
);

   logic        valid_ff, valid_in;
   logic [2:0]  mode_ff, mode_in;
   req_type     blk_ff, blk_in;
   logic        accept;
   logic        push;

   logic [15:0] c0, c1;
   logic [31:0] idx_raw, idx_norm;
   logic        force4, c3clear;

   function automatic logic [7:0] div3(input logic [9:0] n);
      logic [19:0] p;
      p = 20'(n) * 20'd683;
      return p[18:11];
   endfunction

   function automatic logic [31:0] expand565(input logic [15:0] c);
      return {8'hFF, c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
   endfunction

   function automatic logic [3:0][31:0] build_pal(input logic [15:0] k0,
                                                  input logic [15:0] k1,
                                                  input logic f4,
                                                  input logic clr);
      logic [3:0][31:0] p;
      logic [31:0]      e0, e1;
      logic [7:0]       x, y;
      logic [9:0]       s;
      e0 = expand565(k0);
      e1 = expand565(k1);
      p[0] = e0;
      p[1] = e1;
      p[2] = 32'hFF000000;
      p[3] = 32'hFF000000;
      for (int ch = 0; ch < 3; ch++) begin
         x = e0[ch*8 +: 8];
         y = e1[ch*8 +: 8];
         if (f4 || (k0 > k1)) begin
            p[2][ch*8 +: 8] = div3(10'({x, 1'b0}) + 10'(y));
            p[3][ch*8 +: 8] = div3(10'(x) + 10'({y, 1'b0}));
         end else begin
            s = 10'(x) + 10'(y);
            p[2][ch*8 +: 8] = s[8:1];
         end
      end
      if (!(f4 || (k0 > k1))) begin
         p[3] = clr ? 32'h00000000 : 32'hFF000000;
      end
      return p;
   endfunction

   assign req_ready = !valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign push      = valid_ff && cmd_ready;

   always_comb begin
      valid_in = valid_ff;
      mode_in  = mode_ff;
      blk_in   = blk_ff;
      if (accept) begin
         valid_in = 1'b1;
         mode_in  = format_mode;
         blk_in   = req_data;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mode_ff <= mode_in;
      blk_ff  <= blk_in;
   end

   always_comb begin
      c0      = blk_ff.block_word0[15:0];
      c1      = blk_ff.block_word0[31:16];
      idx_raw = blk_ff.block_word0[63:32];
      force4  = 1'b0;
      c3clear = 1'b0;
      case (mode_ff)
         MODE_DXT1_OPAQUE: begin
            c3clear = 1'b0;
         end
         MODE_DXT1_ALPHA: begin
            c3clear = 1'b1;
         end
         MODE_DXT1_BE: begin
            c0      = {blk_ff.block_word0[7:0], blk_ff.block_word0[15:8]};
            c1      = {blk_ff.block_word0[23:16], blk_ff.block_word0[31:24]};
            idx_raw = {blk_ff.block_word0[39:32], blk_ff.block_word0[47:40],
                       blk_ff.block_word0[55:48], blk_ff.block_word0[63:56]};
            c3clear = 1'b1;
         end
         MODE_DXT3, MODE_DXT5: begin
            c0      = blk_ff.block_word1[15:0];
            c1      = blk_ff.block_word1[31:16];
            idx_raw = blk_ff.block_word1[63:32];
            force4  = 1'b1;
         end
         default: begin
            force4 = 1'b1;
         end
      endcase
   end

   // reverse pixel order for the big-endian variant
   always_comb begin
      idx_norm = idx_raw;
      if (mode_ff == MODE_DXT1_BE) begin
         for (int k = 0; k < 16; k++) begin
            idx_norm[2*k +: 2] = idx_raw[2*(15-k) +: 2];
         end
      end
   end

   assign cmd_valid     = valid_ff;
   assign cmd_data.mode = mode_ff;
   assign cmd_data.pal  = build_pal(c0, c1, force4, c3clear);
   assign cmd_data.idx  = idx_norm;
   assign cmd_data.w0   = blk_ff.block_word0;
   assign cmd_data.w1   = blk_ff.block_word1;

endmodule

>>> rtl/bcn_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcn_cmd_queue
// Two-entry command queue between the front and the back of the decoder.
// ----------------------------------------------------------------------------
module bcn_cmd_queue import bcn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_data
);

   cmd_type     entry_ff [2];
   cmd_type     entry_in [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = in_data;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      entry_ff <= entry_in;
   end

`ifndef NO_ASSERTIONS
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count did not advance on push");
   a_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/bcn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcn_back
// Walks the sixteen pixels of a decoded block, selects palette entries and
// alpha/red/green codes, interpolates; one pixel item per cycle, save stalls.
// ----------------------------------------------------------------------------
module bcn_back import bcn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [1:0] KIND_DIRECT = 2'd0;
   localparam logic [1:0] KIND_DIV7   = 2'd1;
   localparam logic [1:0] KIND_DIV5   = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] num;
   } chan_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] color;
      logic [3:0]  nib;
      chan_type    ch0;
      chan_type    ch1;
      logic [3:0]  pos;
      logic        last;
   } p1_type;

   cmd_type     cur_ff, cur_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [3:0]  pix_ff, pix_in;
   p1_type      p1_ff, p1_in;
   logic        p1_valid_ff, p1_valid_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   logic        out_ready, p1_ready, issue, load;
   logic [1:0]  sel;
   logic [7:0]  v0, v1;
   logic [31:0] argb;

   function automatic chan_type chan_setup(input logic [63:0] blk, input logic [3:0] pix);
      logic [7:0] a0, a1;
      logic [2:0] code;
      logic [5:0] bitpos;
      logic [3:0] wa, wb;
      chan_type   c;
      a0     = blk[7:0];
      a1     = blk[15:8];
      bitpos = 6'd16 + {1'b0, pix, 1'b0} + {2'b00, pix};
      code   = blk[bitpos +: 3];
      wa     = 4'd0;
      wb     = 4'd0;
      c.kind = KIND_DIRECT;
      c.num  = 11'd0;
      if (code == 3'd0) begin
         c.num = 11'(a0);
      end else if (code == 3'd1) begin
         c.num = 11'(a1);
      end else if (a0 > a1) begin
         wa     = 4'd8 - 4'(code);
         wb     = 4'(code) - 4'd1;
         c.kind = KIND_DIV7;
         c.num  = 11'(wa) * 11'(a0) + 11'(wb) * 11'(a1);
      end else if (code == 3'd6) begin
         c.num = 11'd0;
      end else if (code == 3'd7) begin
         c.num = 11'd255;
      end else begin
         wa     = 4'd6 - 4'(code);
         wb     = 4'(code) - 4'd1;
         c.kind = KIND_DIV5;
         c.num  = 11'(wa) * 11'(a0) + 11'(wb) * 11'(a1);
      end
      return c;
   endfunction

   function automatic logic [7:0] chan_value(input chan_type c);
      logic [11:0] recip;
      logic [22:0] prod;
      recip = (c.kind == KIND_DIV7) ? 12'd2341 : 12'd3277;
      prod  = 23'(c.num) * 23'(recip);
      return (c.kind == KIND_DIRECT) ? c.num[7:0] : prod[21:14];
   endfunction

   assign out_ready = !out_valid_ff || rsp_ready;
   assign p1_ready  = !p1_valid_ff || out_ready;
   assign issue     = cur_valid_ff && p1_ready;
   assign load      = !cur_valid_ff || (issue && (pix_ff == LAST_PIXEL_POS));
   assign cmd_ready = load;

   // issue stage
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pix_in       = pix_ff;
      if (load) begin
         cur_valid_in = cmd_valid;
         cur_in       = cmd_data;
         pix_in       = 4'd0;
      end else if (issue) begin
         pix_in = pix_ff + 4'd1;
      end
   end

   assign sel = cur_ff.idx[{pix_ff, 1'b0} +: 2];

   always_comb begin
      p1_valid_in = p1_valid_ff;
      p1_in       = p1_ff;
      if (p1_ready) begin
         p1_valid_in = issue;
      end
      if (issue) begin
         p1_in.mode  = cur_ff.mode;
         p1_in.color = cur_ff.pal[sel];
         p1_in.nib   = cur_ff.w0[{pix_ff, 2'b00} +: 4];
         p1_in.ch0   = chan_setup(cur_ff.w0, pix_ff);
         p1_in.ch1   = chan_setup(cur_ff.w1, pix_ff);
         p1_in.pos   = pix_ff;
         p1_in.last  = (pix_ff == LAST_PIXEL_POS);
      end
   end

   // output stage
   assign v0 = chan_value(p1_ff.ch0);
   assign v1 = chan_value(p1_ff.ch1);

   always_comb begin
      case (p1_ff.mode)
         MODE_DXT1_OPAQUE, MODE_DXT1_ALPHA, MODE_DXT1_BE: begin
            argb = p1_ff.color;
         end
         MODE_DXT3: begin
            argb = {p1_ff.nib, p1_ff.nib, p1_ff.color[23:0]};
         end
         MODE_DXT5: begin
            argb = {v0, p1_ff.color[23:0]};
         end
         MODE_BC4: begin
            argb = {8'hFF, v0, 16'h0000};
         end
         MODE_BC5: begin
            argb = {8'hFF, v0, v1, 8'h00};
         end
         default: begin
            argb = 32'h00000000;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_ready) begin
         out_valid_in = p1_valid_ff;
         if (p1_valid_ff) begin
            out_in.pixel_argb     = argb;
            out_in.pixel_position = p1_ff.pos;
            out_in.last_pixel     = p1_ff.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pix_ff       <= 4'd0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pix_ff       <= pix_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff <= cur_in;
      p1_ff  <= p1_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   a_block_end: assert property (@(posedge clock) disable iff (reset)
      (issue && (pix_ff == LAST_PIXEL_POS) && !cmd_valid) |=> !cur_valid_ff)
      else $error("block still active after its last pixel");
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last_pixel) |-> (out_ff.pixel_position == LAST_PIXEL_POS))
      else $error("last pixel flagged at wrong position");
`endif

endmodule

>>> rtl/bcn_texture_block_decoder_unit.sv
`timescale 1ns / 1ps
// Path: a block passes the front register, the command queue, the current
// block register, p1 and the output register; one pixel per cycle
// without stalls. The pixel counter of the back end drives one pixel into the
// output register per cycle, taking the next block with the last pixel.
// Reset: synchronous, active high; clears all valid flags, empties the queue
// and returns format_mode to DXT1 opaque.
// ----------------------------------------------------------------------------
// bcn_texture_block_decoder_unit
// BCn texture block decoder: front end, command queue, pixel back end and the
// format_mode control register.
// ----------------------------------------------------------------------------
module bcn_texture_block_decoder_unit import bcn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic REG_FORMAT_MODE = 1'b0;

   logic [2:0] format_mode_ff, format_mode_in;
   logic       csr_write;
   logic       q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   cmd_type    q_in_data, q_out_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      format_mode_in = format_mode_ff;
      if (csr_write && (paddr[2] == REG_FORMAT_MODE)) begin
         format_mode_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_ff <= MODE_DXT1_OPAQUE;
      end else begin
         format_mode_ff <= format_mode_in;
      end
   end

   assign prdata = (paddr[2] == REG_FORMAT_MODE) ? {29'd0, format_mode_ff} : 32'd0;

   bcn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .format_mode (format_mode_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .cmd_valid   (q_in_valid),
      .cmd_ready   (q_in_ready),
      .cmd_data    (q_in_data)
   );

   bcn_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   bcn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_out_valid),
      .cmd_ready (q_out_ready),
      .cmd_data  (q_out_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
